/* design/uart_can_frame_deframer_resync_macros.svh */
// assertion macros for the frame deframer
// no dependencies; taken in by the top level with `include
`ifndef UART_CAN_FRAME_DEFRAMER_RESYNC_MACROS_SVH
`define UART_CAN_FRAME_DEFRAMER_RESYNC_MACROS_SVH

`ifndef NO_ASSERTIONS

// property that must hold at every clock edge outside reset
`define UCFDR_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("ucfdr assertion failed");

// cause in one cycle, effect in the next
`define UCFDR_ASSERT_NEXT(label, clk, rst, cause, effect) \
   label: assert property (@(posedge clk) disable iff (rst) (cause) |=> (effect)) \
      else $error("ucfdr assertion failed");

`else

`define UCFDR_ASSERT(label, clk, rst, prop)
`define UCFDR_ASSERT_NEXT(label, clk, rst, cause, effect)

`endif

`endif

/* design/ucfdr_pkg.sv */
// shared types and constants of the frame deframer
// no dependencies; imported by every module of the block
package ucfdr_pkg;

   localparam int DataBytes = 8;
   localparam int KeptBytes = 12;

   // frame positions
   localparam logic [3:0] PosIdle   = 4'd0;
   localparam logic [3:0] PosIdHigh = 4'd1;
   localparam logic [3:0] PosIdLow  = 4'd2;
   localparam logic [3:0] PosData0  = 4'd3;
   localparam logic [3:0] PosSize   = 4'd11;
   localparam logic [3:0] PosFooter = 4'd12;

   // register indexes
   localparam logic [0:0] CsrIdxStartMarker = 1'b0;
   localparam logic [0:0] CsrIdxEndMarker   = 1'b1;

   localparam logic [7:0] StartMarkerReset = 8'h01;
   localparam logic [7:0] EndMarkerReset   = 8'h04;

   typedef logic [7:0] byte_type;
   typedef logic [DataBytes-1:0][7:0] data_type;
   typedef logic [3:0] pos_type;

   typedef struct packed {
      byte_type start_marker;
      byte_type end_marker;
   } cfg_type;

   typedef struct packed {
      logic [15:0] msg_id;
      byte_type    msg_size;
      data_type    payload;
   } msg_type;

   typedef struct packed {
      logic    ready;
      pos_type frame_pos;
   } core_status_type;

endpackage

/* design/ucfdr_csr.sv */
// marker registers of the frame deframer
// depends on ucfdr_pkg
module ucfdr_csr (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [0:0]        csr_index,
   input  logic [7:0]        csr_wdata,
   output ucfdr_pkg::cfg_type cfg
);
   import ucfdr_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CsrIdxStartMarker: cfg_in.start_marker = csr_wdata;
            CsrIdxEndMarker:   cfg_in.end_marker   = csr_wdata;
            default:           cfg_in              = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_marker <= StartMarkerReset;
         cfg_ff.end_marker   <= EndMarkerReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* design/ucfdr_core.sv */
// frame state, footer check, resync realignment and result register
// depends on ucfdr_pkg
module ucfdr_core (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      step_valid,
   input  logic [7:0]                step_byte,
   input  ucfdr_pkg::cfg_type        cfg,
   input  logic                      rsp_stall,
   output logic                      rsp_valid,
   output ucfdr_pkg::msg_type        rsp_msg,
   output ucfdr_pkg::core_status_type status
);
   import ucfdr_pkg::*;

   pos_type     pos_ff, pos_in;
   logic [15:0] id_ff, id_in;
   byte_type    size_ff, size_in;
   data_type    data_ff, data_in;
   logic        rsp_valid_ff, rsp_valid_in;
   msg_type     msg_ff, msg_in;

   byte_type               kept [KeptBytes];
   logic [KeptBytes-1:0]   match;
   logic                   found;
   logic [3:0]             start_idx;
   logic [4:0]             src_idx;
   logic [PosSize:PosIdHigh] resync_upd;
   byte_type               shifted [PosIdHigh:PosSize];
   logic [PosSize:PosIdHigh] upd;
   byte_type               val [PosIdHigh:PosSize];
   logic                   emit;

   // kept bytes and first start marker among them
   always_comb begin
      kept[0] = id_ff[15:8];
      kept[1] = id_ff[7:0];
      for (int j = 0; j < DataBytes; j++) begin
         kept[2+j] = data_ff[j];
      end
      kept[10] = size_ff;
      kept[11] = step_byte;
      for (int i = 0; i < KeptBytes; i++) begin
         match[i] = (kept[i] == cfg.start_marker);
      end
      found     = |match;
      start_idx = '0;
      for (int i = KeptBytes - 1; i >= 0; i--) begin
         if (match[i]) begin
            start_idx = 4'(i);
         end
      end
      src_idx = '0;
      for (int k = PosIdHigh; k <= PosSize; k++) begin
         src_idx       = 5'(start_idx) + 5'(k);
         resync_upd[k] = found && (src_idx < 5'(KeptBytes));
         shifted[k]    = (src_idx < 5'(KeptBytes)) ? kept[src_idx[3:0]] : '0;
      end
   end

   // next state
   always_comb begin
      pos_in  = pos_ff;
      id_in   = id_ff;
      size_in = size_ff;
      data_in = data_ff;
      emit    = 1'b0;
      upd     = '0;
      for (int k = PosIdHigh; k <= PosSize; k++) begin
         val[k] = shifted[k];
      end

      if (step_valid) begin
         if (pos_ff == PosFooter) begin
            if (step_byte == cfg.end_marker) begin
               pos_in = PosIdle;
               emit   = 1'b1;
            end else if (found) begin
               upd    = resync_upd;
               pos_in = 4'(KeptBytes) - start_idx;
            end else begin
               pos_in = PosIdle;
            end
         end else if (pos_ff >= PosIdHigh && pos_ff <= PosSize) begin
            for (int k = PosIdHigh; k <= PosSize; k++) begin
               if (pos_ff == 4'(k)) begin
                  upd[k] = 1'b1;
                  val[k] = step_byte;
               end
            end
            pos_in = pos_ff + 4'd1;
         end else begin
            pos_in = match[KeptBytes-1] ? PosIdHigh : PosIdle;
         end
      end

      // high byte clears the low byte, low byte is or-ed in
      if (upd[PosIdHigh]) begin
         id_in = {val[PosIdHigh], 8'h00};
      end
      if (upd[PosIdLow]) begin
         id_in[7:0] = id_in[7:0] | val[PosIdLow];
      end
      for (int j = 0; j < DataBytes; j++) begin
         if (upd[PosData0 + 4'(j)]) begin
            data_in[j] = val[PosData0 + 4'(j)];
         end
      end
      if (upd[PosSize]) begin
         size_in = val[PosSize];
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = emit | (rsp_valid_ff & rsp_stall);
      msg_in       = msg_ff;
      if (emit) begin
         msg_in.msg_id   = id_ff;
         msg_in.msg_size = size_ff;
         msg_in.payload  = data_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= PosIdle;
         id_ff        <= '0;
         size_ff      <= '0;
         data_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         id_ff        <= id_in;
         size_ff      <= size_in;
         data_ff      <= data_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      msg_ff <= msg_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_msg          = msg_ff;
   assign status.ready     = !(rsp_valid_ff && rsp_stall);
   assign status.frame_pos = pos_ff;

endmodule

/* design/uart_can_frame_deframer_resync.sv */
// top level of the 13-byte frame deframer with start-marker resync
// depends on ucfdr_pkg, ucfdr_csr, ucfdr_core and the assertion macro header
//
//   channel   direction  handshake            word
//   req_      in         req_valid/req_stall  req_rx_byte
//   rsp_      out        rsp_valid/rsp_stall  msg_id, msg_size, payload0..7
//   csr_      in         csr_valid/csr_ready  csr_index, csr_wdata
//
// one byte per cycle sustained while rsp_stall holds no waiting message; a taken byte
// sits in the input register while its frame step (footer check, 12-byte start search,
// realign) runs, and the frame state register takes the outcome when the byte steps
// a finished message is loaded into the result register when its end byte steps
// synchronous active-high reset clears the frame state and loads markers 1 and 4
// while rsp_stall holds a waiting message, stepping pauses and req_stall rises
// once the input register is full
`include "uart_can_frame_deframer_resync_macros.svh"

module uart_can_frame_deframer_resync (
   input  logic       clock,
   input  logic       reset,
   // byte input
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   // message output
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [15:0] rsp_msg_id,
   output logic [7:0] rsp_msg_size,
   output logic [7:0] rsp_payload0,
   output logic [7:0] rsp_payload1,
   output logic [7:0] rsp_payload2,
   output logic [7:0] rsp_payload3,
   output logic [7:0] rsp_payload4,
   output logic [7:0] rsp_payload5,
   output logic [7:0] rsp_payload6,
   output logic [7:0] rsp_payload7,
   // marker registers
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [0:0] csr_index,
   input  logic [7:0] csr_wdata
);
   import ucfdr_pkg::*;

   // input register
   logic            in_valid_ff, in_valid_in;
   byte_type        in_byte_ff, in_byte_in;
   logic            req_take;
   logic            step;

   cfg_type         cfg;
   msg_type         msg;
   core_status_type status;
   logic            at_footer;

   ucfdr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // a held byte steps whenever the result register can take a message
   assign step      = in_valid_ff & status.ready;
   // stall only when a byte is held and cannot step
   assign req_stall = in_valid_ff & ~status.ready;
   assign req_take  = req_valid & ~req_stall;

   always_comb begin
      in_valid_in = req_take | (in_valid_ff & ~step);
      in_byte_in  = req_take ? req_rx_byte : in_byte_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
   end

   ucfdr_core u_core (
      .clock      (clock),
      .reset      (reset),
      .step_valid (step),
      .step_byte  (in_byte_ff),
      .cfg        (cfg),
      .rsp_stall  (rsp_stall),
      .rsp_valid  (rsp_valid),
      .rsp_msg    (msg),
      .status     (status)
   );

   // unpack the message word onto its ports
   assign rsp_msg_id   = msg.msg_id;
   assign rsp_msg_size = msg.msg_size;
   assign rsp_payload0 = msg.payload[0];
   assign rsp_payload1 = msg.payload[1];
   assign rsp_payload2 = msg.payload[2];
   assign rsp_payload3 = msg.payload[3];
   assign rsp_payload4 = msg.payload[4];
   assign rsp_payload5 = msg.payload[5];
   assign rsp_payload6 = msg.payload[6];
   assign rsp_payload7 = msg.payload[7];

   assign at_footer = (status.frame_pos == PosFooter);

   // a new message only ever follows a byte taken at the footer position
   `UCFDR_ASSERT(a_msg_from_footer, clock, reset, $rose(rsp_valid) |-> $past(at_footer))
   // frame position never runs past the footer
   `UCFDR_ASSERT(a_pos_in_range, clock, reset, status.frame_pos <= PosFooter)
   // a byte held under stall is neither dropped nor altered
   `UCFDR_ASSERT_NEXT(a_held_byte_kept, clock, reset, req_stall, in_valid_ff && $stable(in_byte_ff))

endmodule

/* test/uart_can_frame_deframer_resync_tb.sv */
// testbench for the 13-byte frame deframer with start-marker realignment
// depends on ucfdr_pkg and the uart_can_frame_deframer_resync top level
`timescale 1ns / 1ps

module uart_can_frame_deframer_resync_tb;
   import ucfdr_pkg::*;

   // scoreboard: mirrors the frame state per accepted byte and holds the
   // messages that the block still owes
   class frame_scoreboard;
      byte_type    start_mark;
      byte_type    end_mark;
      pos_type     frame_pos;
      logic [15:0] ident;
      byte_type    size_byte;
      data_type    data_store;
      msg_type     pending_msgs[$];
      int          errors;
      int          msgs_seen;
      int          realigns;

      function new();
         start_mark = StartMarkerReset;
         end_mark   = EndMarkerReset;
         frame_pos  = PosIdle;
         ident      = '0;
         size_byte  = '0;
         data_store = '0;
         errors     = 0;
         msgs_seen  = 0;
         realigns   = 0;
      endfunction

      function void set_marker(logic [0:0] idx, byte_type v);
         if (idx == CsrIdxStartMarker) start_mark = v;
         else end_mark = v;
      endfunction

      // store a byte as if it had arrived at frame position p
      function void place(pos_type p, byte_type b);
         if (p == PosIdHigh) ident = {b, 8'h00};
         else if (p == PosIdLow) ident = ident | {8'h00, b};
         else if (p == PosSize) size_byte = b;
         else if (p >= PosData0 && p < PosSize) data_store[3'(p - PosData0)] = b;
      endfunction

      // bad footer: hunt for the first start marker among the kept bytes
      function void realign(byte_type last);
         byte_type kept [KeptBytes];
         int s;
         kept[0] = ident[15:8];
         kept[1] = ident[7:0];
         for (int k = 0; k < DataBytes; k++) kept[2 + k] = data_store[k];
         kept[10] = size_byte;
         kept[11] = last;
         s = 0;
         while (s < KeptBytes && kept[s] != start_mark) s++;
         if (s == KeptBytes) begin
            frame_pos = PosIdle;
            return;
         end
         realigns++;
         for (int k = 1; s + k < KeptBytes; k++) place(pos_type'(k), kept[s + k]);
         frame_pos = pos_type'(KeptBytes - s);
      endfunction

      function void deframe_byte(byte_type b);
         msg_type m;
         if (frame_pos == PosFooter) begin
            // footer test first, so equal markers close the frame
            if (b == end_mark) begin
               m.msg_id   = ident;
               m.msg_size = size_byte;
               m.payload  = data_store;
               pending_msgs.push_back(m);
               frame_pos = PosIdle;
            end else begin
               realign(b);
            end
         end else if (frame_pos == PosIdle || frame_pos > PosFooter) begin
            frame_pos = (b == start_mark) ? PosIdHigh : PosIdle;
         end else begin
            place(frame_pos, b);
            frame_pos = frame_pos + 4'd1;
         end
      endfunction

      function void note_mismatch(string field, logic [15:0] want, logic [15:0] got);
         if (errors < 10)
            $display("[%0t] mismatch on %s: expected %h, got %h", $realtime, field, want, got);
         errors++;
      endfunction

      function void check_msg(msg_type got);
         msg_type want;
         msgs_seen++;
         if (pending_msgs.size() == 0) begin
            if (errors < 10)
               $display("[%0t] message id %h arrived with nothing outstanding",
                        $realtime, got.msg_id);
            errors++;
            return;
         end
         want = pending_msgs.pop_front();
         if (got.msg_id !== want.msg_id) note_mismatch("msg_id", want.msg_id, got.msg_id);
         if (got.msg_size !== want.msg_size)
            note_mismatch("msg_size", {8'h00, want.msg_size}, {8'h00, got.msg_size});
         for (int k = 0; k < DataBytes; k++)
            if (got.payload[k] !== want.payload[k])
               note_mismatch($sformatf("payload%0d", k),
                             {8'h00, want.payload[k]}, {8'h00, got.payload[k]});
      endfunction
   endclass

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_stall;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall   = 1'b0;
   logic [15:0] rsp_msg_id;
   logic [7:0]  rsp_msg_size;
   logic [7:0]  rsp_payload0, rsp_payload1, rsp_payload2, rsp_payload3;
   logic [7:0]  rsp_payload4, rsp_payload5, rsp_payload6, rsp_payload7;
   logic        csr_valid   = 1'b0;
   logic        csr_ready;
   logic [0:0]  csr_index   = CsrIdxStartMarker;
   logic [7:0]  csr_wdata   = 8'h00;

   frame_scoreboard sb = new();

   // quiet: both sides run back to back for the current frame
   bit quiet = 1'b0;
   int bytes_sent = 0;
   int settings_run = 1;

   uart_can_frame_deframer_resync u_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_rx_byte  (req_rx_byte),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_msg_id   (rsp_msg_id),
      .rsp_msg_size (rsp_msg_size),
      .rsp_payload0 (rsp_payload0),
      .rsp_payload1 (rsp_payload1),
      .rsp_payload2 (rsp_payload2),
      .rsp_payload3 (rsp_payload3),
      .rsp_payload4 (rsp_payload4),
      .rsp_payload5 (rsp_payload5),
      .rsp_payload6 (rsp_payload6),
      .rsp_payload7 (rsp_payload7),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always #2 clock = ~clock;

   // per-word wait drawn by either side, zero inside quiet stretches
   function automatic int draw_gap();
      return quiet ? 0 : $urandom_range(0, 11);
   endfunction

   // body bytes lean on the marker values so that realignment hits often
   function automatic byte_type rand_body();
      int r;
      r = $urandom_range(0, 15);
      if (r == 0) return sb.start_mark;
      if (r == 1) return sb.end_mark;
      return byte_type'($urandom_range(0, 255));
   endfunction

   // one byte on the input channel; valid stays up for a back-to-back word
   task automatic send_byte(input byte_type b);
      int gap;
      gap = draw_gap();
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (req_stall);
      sb.deframe_byte(b);
      bytes_sent++;
   endtask

   // random traffic: mostly whole frames, some with a bad footer, some cut
   // short, and some loose noise between them
   task automatic send_frame();
      int kind;
      int n;
      byte_type f;
      quiet = ($urandom_range(0, 3) == 0);
      kind  = $urandom_range(0, 9);
      if (kind == 0) begin
         n = $urandom_range(1, 6);
         repeat (n) send_byte(byte_type'($urandom_range(0, 255)));
      end else if (kind == 1) begin
         // truncated frame, the next one runs into it
         send_byte(sb.start_mark);
         n = $urandom_range(0, 10);
         repeat (n) send_byte(rand_body());
      end else if (kind <= 3) begin
         // wrong footer byte forces the start-marker search
         send_byte(sb.start_mark);
         repeat (11) send_byte(rand_body());
         f = rand_body();
         if (f == sb.end_mark) f = f + 8'd1;
         send_byte(f);
      end else begin
         send_byte(sb.start_mark);
         repeat (11) send_byte(rand_body());
         send_byte(sb.end_mark);
      end
   endtask

   task automatic run_random(input int count);
      int stop_at;
      stop_at = bytes_sent + count;
      while (bytes_sent < stop_at) send_frame();
   endtask

   task automatic write_marker(input logic [0:0] idx, input byte_type v);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      do @(posedge clock); while (!csr_ready);
      sb.set_marker(idx, v);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // drop valid, drain every owed message, then let the pipeline empty
   // of bytes that produce nothing (two stages deep)
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending_msgs.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic run_setting(input byte_type s, input byte_type e);
      settle();
      write_marker(CsrIdxStartMarker, s);
      write_marker(CsrIdxEndMarker, e);
      settings_run++;
      // one clean frame right after the change, then random traffic
      send_byte(s);
      repeat (11) send_byte(rand_body());
      send_byte(e);
      run_random(180);
   endtask

   // result side: draw a stall per word, then take the next valid word
   initial begin
      int n;
      msg_type got;
      forever begin
         n = draw_gap();
         @(negedge clock);
         rsp_stall <= (n != 0);
         if (n != 0) begin
            repeat (n) @(negedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!rsp_valid);
         got.msg_id     = rsp_msg_id;
         got.msg_size   = rsp_msg_size;
         got.payload[0] = rsp_payload0;
         got.payload[1] = rsp_payload1;
         got.payload[2] = rsp_payload2;
         got.payload[3] = rsp_payload3;
         got.payload[4] = rsp_payload4;
         got.payload[5] = rsp_payload5;
         got.payload[6] = rsp_payload6;
         got.payload[7] = rsp_payload7;
         sb.check_msg(got);
      end
   end

   initial begin
      byte_type seq[$];
      // reset markers: noise first, a clean frame with extreme fields, then
      // a frame whose footer is wrong with a start marker at data byte 3,
      // finished off from the realigned position
      seq = '{8'h00, 8'hFF,
              8'h01, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'h80, 8'h7F, 8'h55, 8'hAA,
              8'h01, 8'h04, 8'hFF, 8'h04,
              8'h01, 8'h22, 8'h33, 8'h44, 8'h55, 8'h66, 8'h01, 8'h77, 8'h88,
              8'h99, 8'hAA, 8'hBB, 8'hCC,
              8'hDD, 8'hEE, 8'h10, 8'h20, 8'h08, 8'h04};
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      foreach (seq[i]) send_byte(seq[i]);
      run_random(180);
      // marker settings: extremes both ways, equal markers, random, reset pair
      run_setting(8'h00, 8'hFF);
      run_setting(8'hFF, 8'h00);
      run_setting(8'h5A, 8'h5A);
      run_setting(byte_type'($urandom_range(0, 255)), byte_type'($urandom_range(0, 255)));
      run_setting(StartMarkerReset, EndMarkerReset);
      settle();
      repeat (8) @(posedge clock);
      $display("sent %0d bytes under %0d marker settings", bytes_sent, settings_run);
      $display("checked %0d messages, %0d realignments, %0d mismatches",
               sb.msgs_seen, sb.realigns, sb.errors);
      if (sb.errors == 0 && sb.pending_msgs.size() == 0) begin
         $display("uart_can_frame_deframer_resync_tb: PASS");
      end else begin
         $display("uart_can_frame_deframer_resync_tb: FAIL");
      end
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #2_000_000;
      $display("timeout with %0d messages outstanding", sb.pending_msgs.size());
      $display("uart_can_frame_deframer_resync_tb: FAIL");
      $finish;
   end

endmodule
